FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define TSG_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define TSG_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tsg_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Triangle span generator package
// Shared types and result codes of the triangle span generator.
// ---------------------------------------------------------------------------
package tsg_pkg;

    // Result kinds carried on the result channel.
    localparam logic [1:0] KIND_PLANE = 2'd0;
    localparam logic [1:0] KIND_SPAN  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam int IN_DATA_W  = 320;
    localparam int OUT_DATA_W = 384;

    // One queued request, already classified.
    typedef struct packed {
        logic             is_load;
        logic [31:0]      color;
        logic [8:0][31:0] coord;
    } item_t;

    // Request to the slope divider.
    typedef struct packed {
        logic        start;
        logic        neg;
        logic [31:0] num;
        logic [31:0] den;
    } div_req_t;

    // Answer from the slope divider.
    typedef struct packed {
        logic        done;
        logic [31:0] quot;
    } div_rsp_t;

endpackage

FILE: rtl/triangle_span_generator_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Triangle span generator core
// Scanline set-up and two-phase edge walk for one flat-coloured triangle.
// ---------------------------------------------------------------------------
// A load request (func = 0) runs the three inverse slopes one after another
// through the shared radix-16 divider, while the plane products share one
// 33 x 33 multiplier in the shadow of the divisions. A span request
// (func = 1) yields one span or done result. Requests wait in a two-entry
// queue, and each result sits in an output register, so the input side keeps
// taking requests while a result waits to be taken, as long as the queue has
// room.
module triangle_span_generator_core #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, fill_color
    input  logic [tsg_pkg::IN_DATA_W-1:0]   s_tdata,
    // func
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // span_left_x, span_right_x, span_row, span_color, plane_a, plane_b,
    // plane_c, plane_d
    output logic [tsg_pkg::OUT_DATA_W-1:0]  m_tdata,
    // kind
    output logic [1:0]                      m_tuser
);

    tsg_pkg::item_t    head;
    logic              head_valid;
    logic              head_pop;
    tsg_pkg::div_req_t div_req;
    tsg_pkg::div_rsp_t div_rsp;

    // Request queue.
    tsg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop)
    );

    // Shared slope divider.
    tsg_div #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Set-up and walk.
    tsg_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

FILE: rtl/tsg_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Triangle span generator front end
// Accepts requests, tags loads and span requests, and holds them in a
// two-entry queue for the back end.
// ---------------------------------------------------------------------------
module tsg_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tsg_pkg::IN_DATA_W-1:0] s_tdata,  // v0_x v0_y v0_z v1_x .. v2_z fill_color
    input  logic [0:0]                   s_tuser,  // func
    output tsg_pkg::item_t               head,
    output logic                         head_valid,
    input  logic                         head_pop
);

    tsg_pkg::item_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;
    tsg_pkg::item_t in_item;
    logic           push;
    logic           pop;

    // Classify the incoming request.
    always_comb begin
        in_item.is_load = ~s_tuser[0];
        in_item.color   = s_tdata[319:288];
        in_item.coord   = s_tdata[287:0];
    end

    assign s_tready   = (cnt_reg != 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];
    assign push       = s_tvalid & s_tready;
    assign pop        = head_pop & head_valid;

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

FILE: rtl/tsg_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Triangle span generator slope divider
// Radix-16 restoring divider for dx * 2^F / dy, truncated toward zero and
// saturated to 32 bits. Four quotient bits are produced per cycle.
// ---------------------------------------------------------------------------
module tsg_div #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  tsg_pkg::div_req_t req,
    output tsg_pkg::div_rsp_t rsp
);

    localparam int NW    = 32 + COORD_FRAC_BITS;
    localparam int NP    = ((NW + 3) / 4) * 4;
    localparam int STEPS = NP / 4;
    localparam int CW    = $clog2(STEPS + 1);

    logic          busy_reg;
    logic          done_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0]   den_reg;
    logic [31:0]   rem_reg;
    logic [NP-1:0] quo_reg;
    logic [31:0]   rem_step;
    logic [NP-1:0] quo_step;

    // Four restoring steps per cycle.
    always_comb begin
        logic [32:0] r2;
        logic        qbit;
        rem_step = rem_reg;
        quo_step = quo_reg;
        for (int k = 0; k < 4; k++) begin
            r2   = {rem_step, quo_step[NP-1]};
            qbit = (r2 >= {1'b0, den_reg});
            if (qbit) begin
                rem_step = 32'(r2 - {1'b0, den_reg});
            end else begin
                rem_step = r2[31:0];
            end
            quo_step = {quo_step[NP-2:0], qbit};
        end
    end

    // Sign and saturate the finished quotient.
    always_comb begin
        rsp.done = done_reg;
        if (neg_reg) begin
            if (quo_reg > NP'(64'h8000_0000)) begin
                rsp.quot = 32'h8000_0000;
            end else begin
                rsp.quot = 32'(~quo_reg[31:0] + 32'd1);
            end
        end else begin
            if (quo_reg > NP'(64'h7FFF_FFFF)) begin
                rsp.quot = 32'h7FFF_FFFF;
            end else begin
                rsp.quot = quo_reg[31:0];
            end
        end
    end

    // Iteration control and datapath.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(STEPS);
                neg_reg  <= req.neg;
                den_reg  <= req.den;
                rem_reg  <= '0;
                quo_reg  <= NP'({req.num, {COORD_FRAC_BITS{1'b0}}});
            end else if (busy_reg) begin
                rem_reg <= rem_step;
                quo_reg <= quo_step;
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/tsg_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Triangle span generator back end
// Runs triangle set-up (nudge, sort, slopes, plane through a shared
// multiplier) and the two-phase edge walk, and drives the result register.
// ---------------------------------------------------------------------------
module tsg_back #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tsg_pkg::item_t                head,
    input  logic                          head_valid,
    output logic                          head_pop,
    output tsg_pkg::div_req_t             div_req,
    input  tsg_pkg::div_rsp_t             div_rsp,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tsg_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]                    m_tuser
);

    localparam int          ACC_W    = 100;
    localparam int          NUDGE_I  = ((1 << COORD_FRAC_BITS) + 50) / 100;
    localparam logic [31:0] NUDGE    = 32'(NUDGE_I);
    localparam logic [31:0] ONE_UNIT = 32'(1) << COORD_FRAC_BITS;
    localparam logic [4:0]  N_ISSUE  = 5'd18;
    localparam logic [1:0]  DSEL_END = 2'd3;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_UPPER = 2'd1;
    localparam logic [1:0] PH_LOWER = 2'd2;

    typedef enum logic [1:0] {ST_IDLE, ST_NUDGE, ST_SORT, ST_CALC} state_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return s[31:0];
    endfunction

    function automatic logic [63:0] sat64(input logic [ACC_W-1:0] v);
        if ((&v[ACC_W-1:63]) || !(|v[ACC_W-1:63])) begin
            return v[63:0];
        end
        return v[ACC_W-1] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    endfunction

    function automatic logic [32:0] diff33(input logic [31:0] a, input logic [31:0] b);
        return {a[31], a} - {b[31], b};
    endfunction

    state_t      state_reg, state_next;
    logic [31:0] vx_reg [3], vx_next [3];
    logic [31:0] vy_reg [3], vy_next [3];
    logic [31:0] vz_reg [3], vz_next [3];
    logic [31:0] slope_reg [3], slope_next [3];
    logic [31:0] xa_reg, xa_next, xb_reg, xb_next, row_reg, row_next;
    logic [1:0]  phase_reg, phase_next;
    logic        past_reg, past_next;
    logic        lsr_reg, lsr_next;
    logic [31:0] color_reg, color_next;
    logic [1:0]  dsel_reg, dsel_next;
    logic        dstart_reg, dstart_next;
    logic [4:0]  idx_reg, idx_next;
    logic        tvalid_reg, tvalid_next;
    logic [tsg_pkg::OUT_DATA_W-1:0] tdata_reg, tdata_next;
    logic [1:0]  tuser_reg, tuser_next;

    logic        out_free;

    // Multiplier pipeline.
    logic                    issue;
    logic signed [63:0]      opa;
    logic signed [32:0]      opb;
    logic signed [32:0]      mul_a;
    logic signed [65:0]      mul_p;
    logic                    dec_neg, dec_end;
    logic [1:0]              dec_grp;
    logic signed [65:0]      prod_reg;
    logic                    prod_vld_reg, prod_hi_reg, prod_neg_reg, prod_end_reg;
    logic [1:0]              prod_grp_reg;
    logic signed [ACC_W-1:0] acc_reg, term, acc_sum, acc_shift;
    logic [63:0]             na_reg, nb_reg, nc_reg, nd_reg;

    logic [32:0] ax, ay, az, bx, by, bz;

    assign out_free = ~tvalid_reg | m_tready;
    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

    // Edge vectors of the sorted triangle.
    assign ax = diff33(vx_reg[1], vx_reg[0]);
    assign ay = diff33(vy_reg[1], vy_reg[0]);
    assign az = diff33(vz_reg[1], vz_reg[0]);
    assign bx = diff33(vx_reg[1], vx_reg[2]);
    assign by = diff33(vy_reg[1], vy_reg[2]);
    assign bz = diff33(vz_reg[1], vz_reg[2]);

    // Divider operands for the edge now selected.
    always_comb begin
        logic [32:0] dx, dy;
        case (dsel_reg)
            2'd0: begin
                dx = diff33(vx_reg[1], vx_reg[0]);
                dy = diff33(vy_reg[1], vy_reg[0]);
            end
            2'd1: begin
                dx = diff33(vx_reg[2], vx_reg[0]);
                dy = diff33(vy_reg[2], vy_reg[0]);
            end
            default: begin
                dx = diff33(vx_reg[2], vx_reg[1]);
                dy = diff33(vy_reg[2], vy_reg[1]);
            end
        endcase
        div_req.start = dstart_reg;
        div_req.neg   = dx[32];
        div_req.num   = dx[32] ? 32'(~dx + 33'd1) : dx[31:0];
        div_req.den   = dy[31:0];
    end

    // A slope is only kept when its y span is positive.
    logic dy_pos;
    always_comb begin
        logic [32:0] dyp;
        case (dsel_reg)
            2'd0:    dyp = diff33(vy_reg[1], vy_reg[0]);
            2'd1:    dyp = diff33(vy_reg[2], vy_reg[0]);
            default: dyp = diff33(vy_reg[2], vy_reg[1]);
        endcase
        dy_pos = ~dyp[32] & (|dyp);
    end

    // Operand schedule: two halves of each of the nine products.
    always_comb begin
        opa     = '0;
        opb     = '0;
        dec_neg = 1'b0;
        case (idx_reg[4:1])
            4'd0: begin opa = 64'(signed'(ay)); opb = bz; end
            4'd1: begin opa = 64'(signed'(az)); opb = by; dec_neg = 1'b1; end
            4'd2: begin opa = 64'(signed'(az)); opb = bx; end
            4'd3: begin opa = 64'(signed'(ax)); opb = bz; dec_neg = 1'b1; end
            4'd4: begin opa = 64'(signed'(ax)); opb = by; end
            4'd5: begin opa = 64'(signed'(ay)); opb = bx; dec_neg = 1'b1; end
            4'd6: begin opa = na_reg; opb = {vx_reg[1][31], vx_reg[1]}; end
            4'd7: begin opa = nb_reg; opb = {vy_reg[1][31], vy_reg[1]}; end
            4'd8: begin opa = nc_reg; opb = {vz_reg[1][31], vz_reg[1]}; end
            default: begin opa = '0; opb = '0; end
        endcase
        case (idx_reg)
            5'd3:    begin dec_end = 1'b1; dec_grp = 2'd0; end
            5'd7:    begin dec_end = 1'b1; dec_grp = 2'd1; end
            5'd11:   begin dec_end = 1'b1; dec_grp = 2'd2; end
            5'd17:   begin dec_end = 1'b1; dec_grp = 2'd3; end
            default: begin dec_end = 1'b0; dec_grp = 2'd0; end
        endcase
        mul_a = idx_reg[0] ? {opa[63], opa[63:32]} : {1'b0, opa[31:0]};
    end

    assign issue = (state_reg == ST_CALC) && (idx_reg < N_ISSUE);
    assign mul_p = mul_a * opb;

    // Accumulate the registered partial product.
    always_comb begin
        term = ACC_W'(prod_reg);
        if (prod_hi_reg) begin
            term = term <<< 32;
        end
        acc_sum   = prod_neg_reg ? (acc_reg - term) : (acc_reg + term);
        acc_shift = acc_sum >>> COORD_FRAC_BITS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= issue;
            if (issue) begin
                prod_reg     <= mul_p;
                prod_hi_reg  <= idx_reg[0];
                prod_neg_reg <= dec_neg;
                prod_end_reg <= dec_end;
                prod_grp_reg <= dec_grp;
            end
            if (state_reg == ST_SORT) begin
                acc_reg <= '0;
            end else if (prod_vld_reg) begin
                if (prod_end_reg) begin
                    acc_reg <= '0;
                    case (prod_grp_reg)
                        2'd0:    na_reg <= sat64(acc_sum);
                        2'd1:    nb_reg <= sat64(acc_sum);
                        2'd2:    nc_reg <= sat64(acc_sum);
                        default: nd_reg <= sat64(acc_shift);
                    endcase
                end else begin
                    acc_reg <= acc_sum;
                end
            end
        end
    end

    // Edge walk step for a span request.
    logic [31:0] w_xa, w_xb, w_row, w_da, w_db, w_row_next;
    logic [1:0]  w_ph1, w_ph;
    logic        w_past, w_past_next, w_active;
    always_comb begin
        logic p1_end, p2_end;
        logic [32:0] rn;
        p1_end = (phase_reg == PH_UPPER) &&
                 (past_reg || ($signed(row_reg) > $signed(vy_reg[1])));
        w_xa   = (p1_end && lsr_reg) ? vx_reg[1] : xa_reg;
        w_row  = (p1_end && lsr_reg) ? vy_reg[1] : row_reg;
        w_past = (p1_end && lsr_reg) ? 1'b0 : past_reg;
        w_xb   = (p1_end && !lsr_reg) ? vx_reg[1] : xb_reg;
        w_ph1  = p1_end ? PH_LOWER : phase_reg;
        p2_end = (w_ph1 == PH_LOWER) &&
                 (w_past || ($signed(w_row) > $signed(vy_reg[2])));
        w_ph   = p2_end ? PH_IDLE : w_ph1;
        w_active = (w_ph == PH_UPPER) || (w_ph == PH_LOWER);
        if (lsr_reg) begin
            w_da = (w_ph == PH_UPPER) ? slope_reg[0] : slope_reg[2];
            w_db = slope_reg[1];
        end else begin
            w_da = slope_reg[1];
            w_db = (w_ph == PH_UPPER) ? slope_reg[0] : slope_reg[2];
        end
        rn = {w_row[31], w_row} + {1'b0, ONE_UNIT};
        if (rn[32] != rn[31]) begin
            w_row_next  = 32'h7FFF_FFFF;
            w_past_next = 1'b1;
        end else begin
            w_row_next  = rn[31:0];
            w_past_next = w_past;
        end
    end

    // Sequencer.
    always_comb begin
        logic [31:0] sx [3], sy [3], sz [3];
        logic [31:0] t;
        state_next  = state_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        vz_next     = vz_reg;
        slope_next  = slope_reg;
        xa_next     = xa_reg;
        xb_next     = xb_reg;
        row_next    = row_reg;
        phase_next  = phase_reg;
        past_next   = past_reg;
        lsr_next    = lsr_reg;
        color_next  = color_reg;
        dsel_next   = dsel_reg;
        dstart_next = 1'b0;
        idx_next    = idx_reg;
        tvalid_next = tvalid_reg & ~m_tready;
        tdata_next  = tdata_reg;
        tuser_next  = tuser_reg;
        head_pop    = 1'b0;
        sx = vx_reg;
        sy = vy_reg;
        sz = vz_reg;
        t  = '0;
        case (state_reg)
            ST_IDLE: begin
                if (head_valid && out_free) begin
                    head_pop = 1'b1;
                    if (head.is_load) begin
                        for (int i = 0; i < 3; i++) begin
                            vx_next[i] = head.coord[3*i];
                            vy_next[i] = head.coord[3*i+1];
                            vz_next[i] = head.coord[3*i+2];
                        end
                        color_next = head.color;
                        state_next = ST_NUDGE;
                    end else if (w_active) begin
                        tvalid_next = 1'b1;
                        tuser_next  = tsg_pkg::KIND_SPAN;
                        tdata_next  = {256'd0, color_reg, w_row, w_xb, w_xa};
                        xa_next     = sat_add32(w_xa, w_da);
                        xb_next     = sat_add32(w_xb, w_db);
                        row_next    = w_row_next;
                        past_next   = w_past_next;
                        phase_next  = w_ph;
                    end else begin
                        tvalid_next = 1'b1;
                        tuser_next  = tsg_pkg::KIND_DONE;
                        tdata_next  = {256'd0, color_reg, 96'd0};
                        xa_next     = w_xa;
                        xb_next     = w_xb;
                        row_next    = w_row;
                        past_next   = w_past;
                        phase_next  = PH_IDLE;
                    end
                end
            end
            ST_NUDGE: begin
                if ((vy_reg[0] == vy_reg[2]) || (vy_reg[1] == vy_reg[2])) begin
                    vy_next[2] = sat_add32(vy_reg[2], NUDGE);
                end
                if (vy_reg[0] == vy_reg[1]) begin
                    vy_next[1] = sat_add32(vy_reg[1], NUDGE);
                end
                state_next = ST_SORT;
            end
            ST_SORT: begin
                // Three compare-swaps on y, moving whole vertices.
                if ($signed(sy[0]) > $signed(sy[1])) begin
                    t = sx[0]; sx[0] = sx[1]; sx[1] = t;
                    t = sy[0]; sy[0] = sy[1]; sy[1] = t;
                    t = sz[0]; sz[0] = sz[1]; sz[1] = t;
                end
                if ($signed(sy[1]) > $signed(sy[2])) begin
                    t = sx[1]; sx[1] = sx[2]; sx[2] = t;
                    t = sy[1]; sy[1] = sy[2]; sy[2] = t;
                    t = sz[1]; sz[1] = sz[2]; sz[2] = t;
                end
                if ($signed(sy[0]) > $signed(sy[1])) begin
                    t = sx[0]; sx[0] = sx[1]; sx[1] = t;
                    t = sy[0]; sy[0] = sy[1]; sy[1] = t;
                    t = sz[0]; sz[0] = sz[1]; sz[1] = t;
                end
                vx_next     = sx;
                vy_next     = sy;
                vz_next     = sz;
                dsel_next   = 2'd0;
                dstart_next = 1'b1;
                idx_next    = 5'd0;
                state_next  = ST_CALC;
            end
            ST_CALC: begin
                if (issue) begin
                    idx_next = idx_reg + 5'd1;
                end
                if (div_rsp.done && (dsel_reg != DSEL_END)) begin
                    slope_next[dsel_reg] = dy_pos ? div_rsp.quot : 32'd0;
                    dsel_next            = dsel_reg + 2'd1;
                    dstart_next          = (dsel_reg != 2'd2);
                end
                if ((dsel_reg == DSEL_END) && (idx_reg == N_ISSUE) && !prod_vld_reg &&
                    out_free) begin
                    tvalid_next = 1'b1;
                    tuser_next  = tsg_pkg::KIND_PLANE;
                    tdata_next  = {nd_reg, nc_reg, nb_reg, na_reg, color_reg, 96'd0};
                    xa_next     = vx_reg[0];
                    xb_next     = vx_reg[0];
                    row_next    = vy_reg[0];
                    past_next   = 1'b0;
                    phase_next  = PH_UPPER;
                    lsr_next    = ($signed(slope_reg[0]) > $signed(slope_reg[1])) ? 1'b0 : 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_IDLE;
            past_reg   <= 1'b0;
            lsr_reg    <= 1'b0;
            color_reg  <= '0;
            dsel_reg   <= DSEL_END;
            dstart_reg <= 1'b0;
            idx_reg    <= N_ISSUE;
            tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            past_reg   <= past_next;
            lsr_reg    <= lsr_next;
            color_reg  <= color_next;
            dsel_reg   <= dsel_next;
            dstart_reg <= dstart_next;
            idx_reg    <= idx_next;
            tvalid_reg <= tvalid_next;
            vx_reg     <= vx_next;
            vy_reg     <= vy_next;
            vz_reg     <= vz_next;
            slope_reg  <= slope_next;
            xa_reg     <= xa_next;
            xb_reg     <= xb_next;
            row_reg    <= row_next;
            tdata_reg  <= tdata_next;
            tuser_reg  <= tuser_next;
        end
    end

endmodule

FILE: rtl/tsg_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Triangle span generator checker
// Port-level checks on the result channel of the core.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tsg_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tsg_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]                     m_tuser
);

    // A stalled result request holds.
    `TSG_ASSERT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `TSG_ASSERT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Span and done results carry no plane terms.
    `TSG_ASSERT(a_plane_zero, aclk, aresetn, m_tvalid && (m_tuser != tsg_pkg::KIND_PLANE) |-> (m_tdata[383:128] == '0), "plane terms in a non-plane result")

    // Plane and done results carry no span position.
    `TSG_ASSERT(a_span_zero, aclk, aresetn, m_tvalid && (m_tuser != tsg_pkg::KIND_SPAN) |-> (m_tdata[95:0] == '0), "span position in a non-span result")

    // No result is shown in the cycle after a reset edge.
    `TSG_ASSERT_ALWAYS(a_reset_quiet, aclk, !$past(aresetn) |-> !m_tvalid, "result visible after reset")

endmodule

bind triangle_span_generator_core tsg_checker u_tsg_checker (.*);
